FILE: rtl/lzw_variable_width_encoder_defines.svh
// ----------------------------------------------------------------------------
// LZW encoder assertion macros
// Shared assertion forms for the encoder checker.
// ----------------------------------------------------------------------------
`ifndef LZW_VARIABLE_WIDTH_ENCODER_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_DEFINES_SVH

// Checked on every edge outside reset.
`define LZWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define LZWE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// LZW encoder package
// Beat types, code command type and sizing constants for the encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int CODE_W       = $clog2(DICT_ENTRIES);
  localparam int ENTRY_W      = CODE_W + 1;
  localparam int WIDTH_W      = $clog2(CODE_W + 1);
  localparam int ACC_W        = CODE_W + 7;
  localparam int CNT_W        = $clog2(ACC_W + 1);
  localparam int FIRST_ENTRY  = 256;
  localparam int START_WIDTH  = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       stream_end;
  } out_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] width;
    logic               flush;
  } code_cmd_t;

  typedef struct packed {
    logic empty;
    logic room2;
  } queue_stat_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CHILD,
    FE_CHAIN,
    FE_FLUSH
  } front_state_t;

endpackage

FILE: rtl/lzwe_queue.sv
// ----------------------------------------------------------------------------
// LZW encoder command queue
// Short FIFO of code commands between the dictionary front and the packer.
// ----------------------------------------------------------------------------
module lzwe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lzwe_pkg::code_cmd_t push_cmd,
  input  logic                pop,
  output lzwe_pkg::code_cmd_t head_cmd,
  output lzwe_pkg::queue_stat_t stat
);
  import lzwe_pkg::*;

  code_cmd_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head_cmd   = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.room2 = (count <= (QPTR_W+1)'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/lzwe_front.sv
// ----------------------------------------------------------------------------
// LZW encoder dictionary front
// Accepts bytes, walks the child and sibling chains of the dictionary and
// issues code commands for misses and for the end of a stream.
// ----------------------------------------------------------------------------
module lzwe_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  lzwe_pkg::in_beat_t    beat,
  input  lzwe_pkg::queue_stat_t qstat,
  output logic                  ready,
  output logic                  push,
  output lzwe_pkg::code_cmd_t   cmd
);
  import lzwe_pkg::*;

  logic [CODE_W-1:0] child_mem [DICT_ENTRIES];
  logic [CODE_W-1:0] pre_mem   [DICT_ENTRIES];
  logic [7:0]        suf_mem   [DICT_ENTRIES];
  logic [CODE_W-1:0] sib_mem   [DICT_ENTRIES];

  front_state_t       state;
  front_state_t       state_next;
  logic [CODE_W-1:0]  cur;
  logic [ENTRY_W-1:0] ne;
  logic [WIDTH_W-1:0] cw;
  logic               have;
  logic [7:0]         byte_q;
  logic               last_q;
  logic [CODE_W-1:0]  head;
  logic [CODE_W-1:0]  child_q;
  logic [CODE_W-1:0]  ent_pre_q;
  logic [7:0]         ent_suf_q;
  logic [CODE_W-1:0]  ent_sib_q;
  logic [CODE_W-1:0]  probe_q;
  logic               clear_busy;
  logic [CODE_W-1:0]  clear_addr;

  logic               in_range;
  logic               pre_ok;
  logic               suf_ok;
  logic               sib_nil;
  logic               hit;
  logic               miss;
  logic               full;
  logic [CODE_W-1:0]  ent_addr;
  logic [CODE_W-1:0]  sib_val;
  logic [ENTRY_W-1:0] ne_inc;
  logic               grow;

  assign ready   = (state == FE_IDLE) && qstat.room2 && !clear_busy;
  assign full    = (ne == ENTRY_W'(DICT_ENTRIES));
  assign ne_inc  = ne + ENTRY_W'(1);
  assign grow    = (ne_inc > (ENTRY_W'(1) << cw));

  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: begin
        if (take) begin
          if (have) begin
            state_next = FE_CHILD;
          end else if (beat.last_byte) begin
            state_next = FE_FLUSH;
          end
        end
      end
      FE_CHILD: begin
        if (!in_range) begin
          state_next = last_q ? FE_FLUSH : FE_IDLE;
        end else begin
          state_next = FE_CHAIN;
        end
      end
      FE_CHAIN: begin
        if (hit || miss) begin
          state_next = last_q ? FE_FLUSH : FE_IDLE;
        end
      end
      FE_FLUSH: state_next = FE_IDLE;
      default:  state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    in_range  = (child_q >= CODE_W'(FIRST_ENTRY)) && ({1'b0, child_q} < ne);
    pre_ok    = (ent_pre_q == cur);
    suf_ok    = (ent_suf_q == byte_q);
    sib_nil   = (ent_sib_q == '0);
    hit       = (state == FE_CHAIN) && pre_ok && suf_ok;
    miss      = ((state == FE_CHILD) && !in_range) ||
                ((state == FE_CHAIN) && (!pre_ok || (!suf_ok && sib_nil)));
    ent_addr  = (state == FE_CHAIN) ? ent_sib_q : child_q;
    sib_val   = ((state == FE_CHAIN) && pre_ok) ? head : '0;
    push      = miss || (state == FE_FLUSH);
    cmd.code  = cur;
    cmd.width = cw;
    cmd.flush = (state == FE_FLUSH);
  end

  always_ff @(posedge clk) begin
    child_q   <= child_mem[cur];
    ent_pre_q <= pre_mem[ent_addr];
    ent_suf_q <= suf_mem[ent_addr];
    ent_sib_q <= sib_mem[ent_addr];
    probe_q   <= ent_addr;
    if (miss && !full) begin
      pre_mem[ne[CODE_W-1:0]] <= cur;
      suf_mem[ne[CODE_W-1:0]] <= byte_q;
      sib_mem[ne[CODE_W-1:0]] <= sib_val;
    end
    if (clear_busy) begin
      child_mem[clear_addr] <= '0;
    end else if (miss && !full) begin
      child_mem[cur] <= ne[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take && (state == FE_IDLE)) begin
      byte_q <= beat.data_byte;
      last_q <= beat.last_byte;
    end
    if (state == FE_CHILD) begin
      head <= child_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      clear_addr <= clear_addr + CODE_W'(1);
      if (clear_addr == '1) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
      cur   <= '0;
      ne    <= ENTRY_W'(FIRST_ENTRY);
      cw    <= WIDTH_W'(START_WIDTH);
      have  <= 1'b0;
    end else begin
      state <= state_next;
      if (take && (state == FE_IDLE) && !have) begin
        cur  <= CODE_W'(beat.data_byte);
        have <= 1'b1;
      end
      if (hit) begin
        cur <= probe_q;
      end
      if (miss) begin
        cur <= CODE_W'(byte_q);
        if (full) begin
          ne <= ENTRY_W'(FIRST_ENTRY);
          cw <= WIDTH_W'(START_WIDTH);
        end else begin
          ne <= ne_inc;
          if (grow) begin
            cw <= cw + WIDTH_W'(1);
          end
        end
      end
      if (state == FE_FLUSH) begin
        cur  <= '0;
        ne   <= ENTRY_W'(FIRST_ENTRY);
        cw   <= WIDTH_W'(START_WIDTH);
        have <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/lzwe_packer.sv
// ----------------------------------------------------------------------------
// LZW encoder bit packer
// Packs variable width codes MSB first into bytes and pads the final byte.
// ----------------------------------------------------------------------------
module lzwe_packer (
  input  logic                  clk,
  input  logic                  rst,
  input  lzwe_pkg::code_cmd_t   head_cmd,
  input  lzwe_pkg::queue_stat_t qstat,
  output logic                  pop,
  output logic                  pkd_valid,
  input  logic                  pkd_stall,
  output lzwe_pkg::out_beat_t   pkd_data
);
  import lzwe_pkg::*;

  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic              flushing;
  logic              can_load;
  logic              emit_full;
  logic              emit_pad;
  logic [CODE_W-1:0] code_mask;
  logic [ACC_W-1:0]  acc_shift;
  logic [ACC_W-1:0]  acc_pad;

  assign can_load  = !pkd_valid || !pkd_stall;
  assign emit_full = (cnt >= CNT_W'(8));
  assign emit_pad  = flushing && (cnt != '0) && !emit_full;
  assign pop       = !emit_full && !flushing && !qstat.empty;
  assign code_mask = (CODE_W'(1) << head_cmd.width) - CODE_W'(1);
  assign acc_shift = acc >> (cnt - CNT_W'(8));
  assign acc_pad   = acc << (CNT_W'(8) - cnt);

  always_ff @(posedge clk) begin
    if (pop) begin
      acc <= (acc << head_cmd.width) | ACC_W'(head_cmd.code & code_mask);
    end
    if (can_load && emit_full) begin
      pkd_data.packed_byte <= acc_shift[7:0];
      pkd_data.stream_end  <= flushing && (cnt == CNT_W'(8));
    end else if (can_load && emit_pad) begin
      pkd_data.packed_byte <= acc_pad[7:0];
      pkd_data.stream_end  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      flushing  <= 1'b0;
      pkd_valid <= 1'b0;
    end else begin
      if (pop) begin
        cnt      <= cnt + CNT_W'(head_cmd.width);
        flushing <= head_cmd.flush;
      end
      if (can_load && emit_full) begin
        pkd_valid <= 1'b1;
        cnt       <= cnt - CNT_W'(8);
        if (flushing && (cnt == CNT_W'(8))) begin
          flushing <= 1'b0;
        end
      end else if (can_load && emit_pad) begin
        pkd_valid <= 1'b1;
        cnt       <= '0;
        flushing  <= 1'b0;
      end else if (!pkd_stall) begin
        pkd_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/lzw_variable_width_encoder.sv
// ----------------------------------------------------------------------------
// LZW variable width encoder
// Greedy LZW compressor with 8 to 12 bit codes packed MSB first.
// ----------------------------------------------------------------------------
// Channel   Signals                       Beat
// src       src_valid, src_stall          data_byte, last_byte
// pkd       pkd_valid, pkd_stall          packed_byte, stream_end
//
// A byte that opens a stream is taken in the idle state of the dictionary front;
// any other byte then visits the child state, and when the current code has a
// child also one chain state for each sibling visited. A byte that ends a
// stream adds a flush state for the flush command.
// The packer loads each code from a four entry command queue, then emits each
// full output byte, plus a padded final byte at the end of a stream.
// Reset is synchronous and clears control state; after reset a pass over all
// 4096 entries zeroes the child table while input stalls. The other dictionary
// memories are not cleared, as entries outside the live code range are never
// trusted. A stall on the output fills the queue, which then stalls the input.
// ----------------------------------------------------------------------------
module lzw_variable_width_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  lzwe_pkg::in_beat_t  src_data,
  output logic                pkd_valid,
  input  logic                pkd_stall,
  output lzwe_pkg::out_beat_t pkd_data
);
  import lzwe_pkg::*;

  logic        front_ready;
  logic        take;
  logic        push;
  logic        pop;
  code_cmd_t   push_cmd;
  code_cmd_t   head_cmd;
  queue_stat_t qstat;

  assign src_stall = !front_ready;
  assign take      = src_valid && front_ready;

  lzwe_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .beat  (src_data),
    .qstat (qstat),
    .ready (front_ready),
    .push  (push),
    .cmd   (push_cmd)
  );

  lzwe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (qstat)
  );

  lzwe_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .qstat     (qstat),
    .pop       (pop),
    .pkd_valid (pkd_valid),
    .pkd_stall (pkd_stall),
    .pkd_data  (pkd_data)
  );

endmodule

FILE: rtl/lzwe_checker.sv
// ----------------------------------------------------------------------------
// LZW encoder port checker
// Watches the encoder ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "lzw_variable_width_encoder_defines.svh"

module lzwe_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_stall,
  input lzwe_pkg::in_beat_t  src_data,
  input logic                pkd_valid,
  input logic                pkd_stall,
  input lzwe_pkg::out_beat_t pkd_data
);
  import lzwe_pkg::*;

  `LZWE_ASSERT(a_out_hold, pkd_valid && pkd_stall |=> pkd_valid && $stable(pkd_data), "Stalled output beat changed.")
  `LZWE_ASSERT_ALWAYS(a_out_reset, rst |=> !pkd_valid, "Output valid after reset.")
  `LZWE_ASSERT(a_last_busy, src_valid && !src_stall && src_data.last_byte |=> src_stall, "Input taken while a stream is being flushed.")

endmodule

bind lzw_variable_width_encoder lzwe_checker u_lzwe_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_data  (src_data),
  .pkd_valid (pkd_valid),
  .pkd_stall (pkd_stall),
  .pkd_data  (pkd_data)
);
